[rtl/sobel_gradient_magnitude_unit_macros.svh]
// ---------------------------------------------------------------------------
// Sobel gradient magnitude unit - assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_UNIT_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SGM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgm assertion failed");

// next-cycle implication, disabled during reset
`define SGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgm assertion failed");

`endif

[rtl/sgm_pkg.sv]
// ---------------------------------------------------------------------------
// sgm_pkg
// Types and constants shared by the Sobel gradient magnitude unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgm_pkg;

  localparam int PIXEL_BITS    = 8;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 13;
  localparam int ROW_BITS      = 12;
  localparam int MAG_BITS      = 11;
  localparam int SQ_BITS       = 21;
  localparam int ROOT_STEPS    = 11;
  localparam int FIFO_DEPTH    = 2;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

  // register index, decoded from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // one window update plus up to two results
  typedef struct packed {
    logic   clear;
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
    logic   emit1;
    logic   emit2;
    logic   eof;
  } cmd_t;

  typedef enum logic {F_IDLE, F_WRITE} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ZERO, B_GRAD, B_SQX, B_SQY, B_ROOT, B_PUSH
  } back_state_t;

endpackage

[rtl/sgm_front.sv]
// ---------------------------------------------------------------------------
// sgm_front
// Accepts pixels and drain steps, tracks raster position, owns the two line
// stores and turns each item into a window command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgm_front #(
  parameter int MAX_WIDTH = sgm_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           restart,
  input  logic [sgm_pkg::WIDTH_BITS-1:0]  frame_width,
  input  logic [sgm_pkg::HEIGHT_BITS-1:0] frame_height,
  input  logic                           in_valid,
  input  logic                           in_mode,
  input  sgm_pkg::pixel_t                in_pixel,
  output logic                           in_ready,
  input  logic                           fifo_full,
  output logic                           push,
  output sgm_pkg::cmd_t                  cmd
);
  import sgm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;

  front_state_t     state_r, state_nxt;
  logic [AW-1:0]    col_r, col_nxt;
  logic [AW-1:0]    drain_r, drain_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic             draining_r, draining_nxt;
  logic             mode_r;
  pixel_t           pix_r;

  pixel_t upper_mem [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];
  pixel_t rd_upper_r, rd_middle_r;

  logic [CW-1:0]          eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;
  logic                   take;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;
  logic                   row_end, frame_end, drain_end;

  always_comb begin
    if (frame_width == '0) eff_w = CW'(1);
    else if (32'(frame_width) > MAX_WIDTH) eff_w = CW'(MAX_WIDTH);
    else eff_w = CW'(frame_width);
    if (frame_height == '0) eff_h = HEIGHT_BITS'(1);
    else if (frame_height > HEIGHT_LIMIT) eff_h = HEIGHT_LIMIT;
    else eff_h = frame_height;
  end

  assign in_ready = (state_r == F_IDLE) && !fifo_full;
  // an item that does not fit the current phase is dropped
  assign take = in_valid && in_ready &&
                ((in_mode == MODE_PIXEL) ? !draining_r : draining_r);

  always_comb begin
    if (state_r == F_IDLE) rd_addr = (in_mode == MODE_DRAIN) ? drain_r : col_r;
    else rd_addr = (mode_r == MODE_DRAIN) ? drain_r : col_r;
  end

  assign row_end   = (CW'(col_r) + CW'(1)) >= eff_w;
  assign drain_end = (CW'(drain_r) + CW'(1)) >= eff_w;
  assign frame_end = (HEIGHT_BITS'(row_r) + HEIGHT_BITS'(1)) >= eff_h;

  // next state
  always_comb begin
    unique case (state_r)
      F_IDLE:  state_nxt = take ? F_WRITE : F_IDLE;
      F_WRITE: state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    push         = 1'b0;
    mem_we       = 1'b0;
    cmd          = '0;
    col_nxt      = col_r;
    row_nxt      = row_r;
    drain_nxt    = drain_r;
    draining_nxt = draining_r;
    if (state_r == F_WRITE) begin
      push = 1'b1;
      if (mode_r == MODE_PIXEL) begin
        mem_we    = 1'b1;
        cmd.clear = (col_r == '0);
        cmd.top   = (row_r >= ROW_BITS'(2)) ? rd_upper_r : '0;
        cmd.mid   = (row_r != '0) ? rd_middle_r : '0;
        cmd.bot   = pix_r;
        cmd.emit1 = (row_r != '0) && (col_r != '0);
        cmd.emit2 = row_end && (row_r != '0);
        if (row_end) begin
          col_nxt = '0;
          if (frame_end) begin
            draining_nxt = 1'b1;
            drain_nxt    = '0;
          end else begin
            row_nxt = row_r + ROW_BITS'(1);
          end
        end else begin
          col_nxt = col_r + AW'(1);
        end
      end else begin
        cmd.clear = (drain_r == '0);
        cmd.top   = (row_r != '0) ? rd_upper_r : '0;
        cmd.mid   = rd_middle_r;
        cmd.emit1 = (drain_r != '0);
        cmd.emit2 = drain_end;
        cmd.eof   = drain_end;
        if (drain_end) begin
          col_nxt      = '0;
          row_nxt      = '0;
          drain_nxt    = '0;
          draining_nxt = 1'b0;
        end else begin
          drain_nxt = drain_r + AW'(1);
        end
      end
    end
    if (restart) begin
      col_nxt      = '0;
      row_nxt      = '0;
      drain_nxt    = '0;
      draining_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      col_r      <= '0;
      row_r      <= '0;
      drain_r    <= '0;
      draining_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      drain_r    <= drain_nxt;
      draining_r <= draining_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= in_mode;
      pix_r  <= in_pixel;
    end
  end

  // line stores: read on accept, written back in the cycle after
  always_ff @(posedge clk) begin
    rd_upper_r  <= upper_mem[rd_addr];
    rd_middle_r <= middle_mem[rd_addr];
    if (mem_we) begin
      upper_mem[rd_addr]  <= rd_middle_r;
      middle_mem[rd_addr] <= pix_r;
    end
  end

endmodule

[rtl/sgm_fifo.sv]
// ---------------------------------------------------------------------------
// sgm_fifo
// Short command queue between front and back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgm_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sgm_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sgm_pkg::cmd_t head
);
  import sgm_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_t              mem_r [FIFO_DEPTH];
  logic [PW-1:0]     wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = wr_r + PW'(1);
    if (pop) rd_nxt = rd_r + PW'(1);
    if (push && !pop) cnt_nxt = cnt_r + (PW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_cmd;
  end

endmodule

[rtl/sgm_back.sv]
// ---------------------------------------------------------------------------
// sgm_back
// 3x3 window, Sobel kernels, squares and an iterative square root; holds
// one finished result in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fifo_empty,
  input  sgm_pkg::cmd_t               head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sgm_pkg::MAG_BITS-1:0] out_mag,
  output logic                        out_eor,
  output logic                        out_eof,
  output logic                        out_last
);
  import sgm_pkg::*;

  localparam int SB = SQ_BITS;

  back_state_t state_r, state_nxt;
  pixel_t      win_r [3][3];
  pixel_t      win_nxt [3][3];
  logic        eor_r, eor_nxt, eof_r, eof_nxt, last_r, last_nxt;
  logic        pend2_r, pend2_nxt, eof2_r, eof2_nxt;
  logic signed [11:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [SB-1:0] sq_r, sq_nxt;
  logic [SB-1:0] v_r, v_nxt;
  logic [SB:0]   res_r, res_nxt;
  logic [SB-1:0] bit_r, bit_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [MAG_BITS-1:0] omag_r, omag_nxt;
  logic          oeor_r, oeor_nxt, oeof_r, oeof_nxt, olast_r, olast_nxt;

  logic slot_free;
  logic signed [11:0] p [3][3];
  logic signed [23:0] prod;
  logic [SB+1:0] trial;

  assign slot_free = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign out_mag   = omag_r;
  assign out_eor   = oeor_r;
  assign out_eof   = oeof_r;
  assign out_last  = olast_r;

  always_comb begin
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        p[a][b] = $signed({4'b0, win_r[a][b]});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!fifo_empty) begin
          if (head.emit1) state_nxt = B_GRAD;
          else if (head.emit2) state_nxt = B_ZERO;
        end
      end
      B_ZERO: state_nxt = B_GRAD;
      B_GRAD: state_nxt = B_SQX;
      B_SQX:  state_nxt = B_SQY;
      B_SQY:  state_nxt = B_ROOT;
      B_ROOT: if (cnt_r == 4'(ROOT_STEPS - 1)) state_nxt = B_PUSH;
      B_PUSH: if (slot_free) state_nxt = pend2_r ? B_ZERO : B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    pop        = 1'b0;
    win_nxt    = win_r;
    eor_nxt    = eor_r;
    eof_nxt    = eof_r;
    last_nxt   = last_r;
    pend2_nxt  = pend2_r;
    eof2_nxt   = eof2_r;
    gx_nxt     = gx_r;
    gy_nxt     = gy_r;
    sq_nxt     = sq_r;
    v_nxt      = v_r;
    res_nxt    = res_r;
    bit_nxt    = bit_r;
    cnt_nxt    = cnt_r;
    omag_nxt   = omag_r;
    oeor_nxt   = oeor_r;
    oeof_nxt   = oeof_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r && !out_ready;
    prod       = '0;
    trial      = '0;
    unique case (state_r)
      B_IDLE: begin
        if (!fifo_empty) begin
          pop = 1'b1;
          for (int k = 0; k < 3; k++) begin
            win_nxt[k][0] = head.clear ? '0 : win_r[k][1];
            win_nxt[k][1] = head.clear ? '0 : win_r[k][2];
          end
          win_nxt[0][2] = head.top;
          win_nxt[1][2] = head.mid;
          win_nxt[2][2] = head.bot;
          pend2_nxt = head.emit2;
          eof2_nxt  = head.eof;
          eor_nxt   = 1'b0;
          eof_nxt   = 1'b0;
          last_nxt  = !head.emit2;
        end
      end
      B_ZERO: begin
        // right-edge result: shift in an all-zero column
        for (int k = 0; k < 3; k++) begin
          win_nxt[k][0] = win_r[k][1];
          win_nxt[k][1] = win_r[k][2];
          win_nxt[k][2] = '0;
        end
        eor_nxt   = 1'b1;
        eof_nxt   = eof2_r;
        last_nxt  = 1'b1;
        pend2_nxt = 1'b0;
      end
      B_GRAD: begin
        gx_nxt = p[0][2] - p[0][0] + ((p[1][2] - p[1][0]) <<< 1) + p[2][2] - p[2][0];
        gy_nxt = p[2][0] - p[0][0] + ((p[2][1] - p[0][1]) <<< 1) + p[2][2] - p[0][2];
      end
      B_SQX: begin
        prod   = gx_r * gx_r;
        sq_nxt = prod[SB-1:0];
      end
      B_SQY: begin
        prod    = gy_r * gy_r;
        v_nxt   = sq_r + prod[SB-1:0];
        res_nxt = '0;
        bit_nxt = SB'(1) << (SB - 1);
        cnt_nxt = '0;
      end
      B_ROOT: begin
        // one result bit per cycle, restoring digit recurrence
        trial = (SB+2)'(res_r) + (SB+2)'(bit_r);
        if ((SB+2)'(v_r) >= trial) begin
          v_nxt   = v_r - trial[SB-1:0];
          res_nxt = (res_r >> 1) + (SB+1)'(bit_r);
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 4'd1;
      end
      B_PUSH: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          omag_nxt   = res_r[MAG_BITS-1:0];
          oeor_nxt   = eor_r;
          oeof_nxt   = eof_r;
          olast_nxt  = last_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
      pend2_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      pend2_r  <= pend2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r   <= win_nxt;
    eor_r   <= eor_nxt;
    eof_r   <= eof_nxt;
    last_r  <= last_nxt;
    eof2_r  <= eof2_nxt;
    gx_r    <= gx_nxt;
    gy_r    <= gy_nxt;
    sq_r    <= sq_nxt;
    v_r     <= v_nxt;
    res_r   <= res_nxt;
    bit_r   <= bit_nxt;
    cnt_r   <= cnt_nxt;
    omag_r  <= omag_nxt;
    oeor_r  <= oeor_nxt;
    oeof_r  <= oeof_nxt;
    olast_r <= olast_nxt;
  end

endmodule

[rtl/sobel_gradient_magnitude_unit.sv]
// A result passes states B_GRAD (after B_ZERO for a right-edge one), B_SQX,
// B_SQY, B_ROOT and B_PUSH; results trail the input stream by one pixel row.
// The front end reads the line stores on accept and writes them back before
// its next item; the back end pops no command until its results are pushed.
// Reset: rst_n (sync, active low) clears control, width 640, height 480;
// line stores are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// sobel_gradient_magnitude_unit
// Streaming 3x3 Sobel gradient magnitude with APB-style configuration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_gradient_magnitude_unit #(
  parameter int MAX_WIDTH = sgm_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [10:0] magnitude, [15:11] zero
  output logic [1:0]  out_tuser,  // [0] end_of_row, [1] end_of_frame
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sgm_pkg::*;

  logic [WIDTH_BITS-1:0]  width_r, width_nxt;
  logic [HEIGHT_BITS-1:0] height_r, height_nxt;
  logic                   cfg_wr;
  logic                   fifo_full, fifo_empty, push, pop;
  cmd_t                   cmd, head;
  logic [MAG_BITS-1:0]    mag;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? 32'(height_r) : 32'(width_r);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_WIDTH) width_nxt = cfg_pwdata[WIDTH_BITS-1:0];
      else height_nxt = cfg_pwdata[HEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  sgm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (cfg_wr),
    .frame_width  (width_r),
    .frame_height (height_r),
    .in_valid     (in_tvalid),
    .in_mode      (in_tuser[0]),
    .in_pixel     (in_tdata),
    .in_ready     (in_tready),
    .fifo_full    (fifo_full),
    .push         (push),
    .cmd          (cmd)
  );

  sgm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .full     (fifo_full),
    .pop      (pop),
    .empty    (fifo_empty),
    .head     (head)
  );

  sgm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_mag    (mag),
    .out_eor    (out_tuser[0]),
    .out_eof    (out_tuser[1]),
    .out_last   (out_tlast)
  );

  assign out_tdata = 16'(mag);

endmodule

[rtl/sgm_checker.sv]
// ---------------------------------------------------------------------------
// sgm_checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sobel_gradient_magnitude_unit_macros.svh"

module sgm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  `SGM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `SGM_ASSERT_SAME(a_mag_range, clk, rst_n, out_tvalid, out_tdata <= 16'd1442)
  `SGM_ASSERT_SAME(a_eof_is_eor, clk, rst_n, out_tvalid && out_tuser[1], out_tuser[0])
  `SGM_ASSERT_SAME(a_eor_is_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast)

endmodule

bind sobel_gradient_magnitude_unit sgm_checker u_sgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
